// ===== hw/rtl/mtf_enc_pkg.sv =====
`timescale 1ns / 1ps

package mtf_enc_pkg;

    // list storage, one cell per symbol
    localparam int MAX_SYMBOLS = 1024;
    localparam int SYM_W       = $clog2(MAX_SYMBOLS);

    // fixed field widths
    localparam int ALPHA_W = 11;
    localparam int POS_W   = 10;

    // compare width wide enough for both the symbol field and MAX_SYMBOLS itself
    localparam int CMP_W = (SYM_W + 1 > ALPHA_W) ? SYM_W + 1 : ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1024);
    localparam logic [CMP_W-1:0]   MAX_SIZE    = CMP_W'(MAX_SYMBOLS);
    localparam logic [SYM_W-1:0]   LAST_IDX    = SYM_W'(MAX_SYMBOLS - 1);

    // control handed from the sequencer to the head of the chain
    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] idx;
        logic             restart;
        logic             bad;
        logic [SYM_W-1:0] key;
    } mtf_step_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } mtf_state_t;

endpackage

// ===== hw/rtl/mtf_enc_cell.sv =====
`timescale 1ns / 1ps

module mtf_enc_cell
    import mtf_enc_pkg::*;
(
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [SYM_W-1:0] d,
    output logic [SYM_W-1:0] q
);

    logic [SYM_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule

// ===== hw/rtl/mtf_enc_head.sv =====
`timescale 1ns / 1ps

module mtf_enc_head
    import mtf_enc_pkg::*;
(
    input  logic             aclk,
    input  mtf_step_t        step,
    input  logic [SYM_W-1:0] ring_out,
    output logic [SYM_W-1:0] ring_in,
    output logic             hit_any,
    output logic [SYM_W-1:0] pos
);

    logic [SYM_W-1:0] carry_reg, carry_next;
    logic             found_reg, found_next;
    logic [SYM_W-1:0] pos_reg, pos_next;
    logic [SYM_W-1:0] elem;
    logic             first;
    logic             match;

    always_comb begin
        // identity order is regenerated from the index on a restart
        elem       = step.restart ? step.idx : ring_out;
        first      = (step.idx == '0);
        match      = (elem == step.key);
        ring_in    = elem;
        carry_next = carry_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        if (!step.bad) begin
            if (first) begin
                // key goes to the front, old front element is carried back
                ring_in    = step.key;
                found_next = match;
                carry_next = elem;
                pos_next   = '0;
            end else if (!found_reg) begin
                ring_in    = carry_reg;
                carry_next = elem;
                if (match) begin
                    found_next = 1'b1;
                    pos_next   = step.idx;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step.en) begin
            carry_reg <= carry_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    assign hit_any = found_next;
    assign pos     = pos_next;

endmodule

// ===== hw/rtl/move_to_front_encoder_top.sv =====
`timescale 1ns / 1ps
// channel   direction  ports                                  transfer when
// input     in         s_valid s_ready s_symbol s_restart     s_valid & s_ready
// result    out        m_valid m_ready m_position m_bad_symbol m_valid & m_ready
// config    in         cfg_wr_en cfg_wr_data                  cfg_wr_en
//
// a symbol is accepted, then the cell ring makes one full rotation, one list entry
// through the head cell per cycle unless the final step waits for the result slot
// reset clears control only; the first symbol after reset rebuilds identity order
// a stalled result holds the ring on its last step until the output slot frees
// the input is taken again in the cycle after the result is registered

module move_to_front_encoder_top
    import mtf_enc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [ALPHA_W-1:0] cfg_wr_data,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ALPHA_W-1:0] s_symbol,
    input  logic               s_restart,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [POS_W-1:0]   m_position,
    output logic               m_bad_symbol
);

    mtf_state_t         state_reg, state_next;
    logic [ALPHA_W-1:0] alphabet_size_reg;
    logic               fresh_reg, fresh_next;
    logic [SYM_W-1:0]   idx_reg, idx_next;
    logic [SYM_W-1:0]   key_reg, key_next;
    logic               bad_reg, bad_next;
    logic               restart_reg, restart_next;
    logic               m_valid_reg, m_valid_next;
    logic [POS_W-1:0]   m_position_reg, m_position_next;
    logic               m_bad_reg, m_bad_next;

    logic [CMP_W-1:0]       size_eff;
    logic [CMP_W-1:0]       sym_cmp;
    logic [CMP_W-1:0]       sym_dec;
    logic                   bad_in;
    logic                   accept;
    logic                   out_block;
    logic                   last;
    logic                   step_en;
    mtf_step_t              step;
    logic [SYM_W-1:0]       ring_in;
    logic                   hit_any;
    logic [SYM_W-1:0]       head_pos;
    logic [SYM_W+POS_W-1:0] pos_wide;
    logic [SYM_W-1:0]       cell_q [MAX_SYMBOLS];

    // size register, saturated to the ring length where it is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alphabet_size_reg <= ALPHA_RESET;
        end else if (cfg_wr_en) begin
            alphabet_size_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        size_eff = (CMP_W'(alphabet_size_reg) > MAX_SIZE) ? MAX_SIZE
                                                          : CMP_W'(alphabet_size_reg);
        sym_cmp  = CMP_W'(s_symbol);
        sym_dec  = sym_cmp - CMP_W'(1);
        bad_in   = (s_symbol == '0) || (sym_cmp > size_eff);
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_block = m_valid_reg && !m_ready;
    assign last      = (idx_reg == LAST_IDX);
    // the final step waits for a free result slot
    assign step_en   = (state_reg == ST_SCAN) && !(last && out_block);

    assign step.en      = step_en;
    assign step.idx     = idx_reg;
    assign step.restart = restart_reg;
    assign step.bad     = bad_reg;
    assign step.key     = key_reg;

    assign pos_wide = {{POS_W{1'b0}}, head_pos};

    always_comb begin
        state_next      = state_reg;
        fresh_next      = fresh_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        bad_next        = bad_reg;
        restart_next    = restart_reg;
        m_valid_next    = m_valid_reg;
        m_position_next = m_position_reg;
        m_bad_next      = m_bad_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next     = sym_dec[SYM_W-1:0];
                    bad_next     = bad_in;
                    restart_next = s_restart || fresh_reg;
                    fresh_next   = 1'b0;
                    idx_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step_en) begin
                    idx_next = idx_reg + SYM_W'(1);
                    if (last) begin
                        m_valid_next    = 1'b1;
                        m_position_next = bad_reg ? '0 : pos_wide[POS_W-1:0];
                        m_bad_next      = bad_reg;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fresh_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        bad_reg        <= bad_next;
        restart_reg    <= restart_next;
        m_position_reg <= m_position_next;
        m_bad_reg      <= m_bad_next;
    end

    // list entries leave the last cell in list order and re-enter at cell 0
    mtf_enc_head u_head (
        .aclk     (aclk),
        .step     (step),
        .ring_out (cell_q[MAX_SYMBOLS-1]),
        .ring_in  (ring_in),
        .hit_any  (hit_any),
        .pos      (head_pos)
    );

    for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
        if (i == 0) begin : g_first
            mtf_enc_cell u_cell (
                .aclk     (aclk),
                .shift_en (step_en),
                .d        (ring_in),
                .q        (cell_q[i])
            );
        end else begin : g_rest
            mtf_enc_cell u_cell (
                .aclk     (aclk),
                .shift_en (step_en),
                .d        (cell_q[i-1]),
                .q        (cell_q[i])
            );
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_position   = m_position_reg;
    assign m_bad_symbol = m_bad_reg;

    // a rejected symbol always reports front position
    a_bad_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_symbol |-> m_position == '0)
        else $error("bad symbol result with nonzero position");

    // results only come out of a finished rotation
    a_result_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_SCAN))
        else $error("result raised outside a scan");

    // a valid symbol must be found by the end of the rotation
    a_symbol_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && last && step_en && !bad_reg |-> hit_any)
        else $error("valid symbol not found in list");

    // each transfer starts a rotation at list position zero
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("scan did not start at position zero");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mtf_enc_pkg::*;

    // one input item as the feeder presents it
    typedef struct {
        logic [ALPHA_W-1:0] symbol;
        logic               restart;
        logic               drain_first;  // hold the item back until no result is owed
    } mtf_item_t;

    // one predicted result
    typedef struct {
        logic [POS_W-1:0] position;
        logic             bad_symbol;
    } mtf_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [ALPHA_W-1:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ALPHA_W-1:0] s_symbol = '0;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [POS_W-1:0]   m_position;
    logic               m_bad_symbol;

    // symbols waiting to be sent and the positions still owed by the block
    mtf_item_t   symbol_q[$];
    mtf_result_t position_q[$];

    // private copy of the symbol list and the alphabet size register
    logic [SYM_W-1:0]   order_list[MAX_SYMBOLS];
    logic [ALPHA_W-1:0] alpha_model;

    int n_presented = 0;   // items raised on s_valid
    int n_accepted  = 0;   // input transfers seen
    int error_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    logic calm = 1'b0;     // no idling on either side while set

    // stimulus-side history, used to aim at small list positions
    logic [ALPHA_W-1:0] recent[8];
    int                 recent_n;

    move_to_front_encoder_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_bad_symbol (m_bad_symbol)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // move-to-front lookup on the private list: returns the position before the move
    function automatic void mtf_lookup(input logic [ALPHA_W-1:0] sym, input logic rst,
                                       output logic [POS_W-1:0] pos, output logic bad);
        int eff;
        int k;
        int found;
        logic [SYM_W-1:0] key;
        eff = (alpha_model > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(alpha_model);
        // restart is honored even when the symbol turns out to be bad
        if (rst) begin
            for (k = 0; k < MAX_SYMBOLS; k++) order_list[k] = SYM_W'(k);
        end
        pos = '0;
        bad = 1'b0;
        if (sym == 0 || int'(sym) > eff) begin
            // out-of-range symbol: flag it, list untouched
            bad = 1'b1;
            return;
        end
        key = SYM_W'(sym - 1);
        found = 0;
        for (k = 0; k < MAX_SYMBOLS; k++) begin
            if (order_list[k] == key) begin
                found = k;
                break;
            end
        end
        // entries ahead of the symbol slide back by one
        for (k = found; k > 0; k--) order_list[k] = order_list[k - 1];
        order_list[0] = key;
        pos = POS_W'(found);
    endfunction

    // feeder: drives the input channel at the falling edge
    always @(negedge aclk) begin : feeder
        mtf_item_t head;
        logic      go;
        // keep valid and payload steady until the current item is taken
        if (aresetn && !(s_valid && n_accepted != n_presented)) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (symbol_q.size() > 0) begin
                if (symbol_q[0].drain_first && position_q.size() != 0) begin
                    go = 1'b0;
                end else if (!calm && $urandom_range(0, 99) < 9) begin
                    // now and then a long gap, so the next symbol lands at any point
                    if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 1100);
                end else begin
                    go = 1'b1;
                end
            end
            if (go) begin
                head = symbol_q.pop_front();
                s_symbol  <= head.symbol;
                s_restart <= head.restart;
                s_valid   <= 1'b1;
                n_presented++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink: random back-pressure on the result channel
    always @(negedge aclk) begin : sink
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 9) begin
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: mirrors register writes, predicts on each input transfer,
    // checks each result transfer against the oldest prediction
    always @(posedge aclk) begin : monitor
        mtf_result_t      want;
        logic [POS_W-1:0] pos;
        logic             bad;
        if (!aresetn) begin
            alpha_model = ALPHA_RESET;
            for (int k = 0; k < MAX_SYMBOLS; k++) order_list[k] = SYM_W'(k);
        end else begin
            if (cfg_wr_en) alpha_model = cfg_wr_data;
            // result first: it belongs to an older transfer than any taken this edge
            if (m_valid && m_ready) begin
                if (position_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch %0d: result pos %0d bad %0b with none expected",
                                 error_count, m_position, m_bad_symbol);
                end else begin
                    want = position_q.pop_front();
                    if (m_position !== want.position || m_bad_symbol !== want.bad_symbol) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch %0d: expected pos %0d bad %0b, got pos %0d bad %0b",
                                     error_count, want.position, want.bad_symbol,
                                     m_position, m_bad_symbol);
                    end
                end
            end
            if (s_valid && s_ready) begin
                mtf_lookup(s_symbol, s_restart, pos, bad);
                want.position   = pos;
                want.bad_symbol = bad;
                position_q.insert(position_q.size(), want);
                n_accepted++;
            end
        end
    end

    task automatic push_item(input int sym, input logic rst, input logic drain);
        mtf_item_t it;
        it.symbol      = ALPHA_W'(sym);
        it.restart     = rst;
        it.drain_first = drain;
        symbol_q.insert(symbol_q.size(), it);
    endtask

    // wait until nothing is queued, in flight or owed, then add spare idle cycles
    task automatic wait_idle();
        while (symbol_q.size() != 0 || n_accepted != n_presented || position_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [ALPHA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random symbols for one alphabet size: mostly valid, many recently used,
    // a few out of range, occasional restarts and drain points
    task automatic gen_random(input int count, input logic [ALPHA_W-1:0] size_value);
        int eff;
        int r;
        int sym;
        eff = (size_value > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(size_value);
        recent_n = 0;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 7 || eff == 0) begin
                if ($urandom_range(0, 3) == 0) sym = 0;
                else sym = $urandom_range(eff + 1, 2047);
            end else if (r < 40 && recent_n > 0) begin
                sym = recent[$urandom_range(0, recent_n - 1)];
            end else begin
                sym = $urandom_range(1, eff);
            end
            if (sym != 0 && sym <= eff) begin
                if (recent_n < 8) begin
                    recent[recent_n] = ALPHA_W'(sym);
                    recent_n++;
                end else begin
                    recent[$urandom_range(0, 7)] = ALPHA_W'(sym);
                end
            end
            push_item(sym, $urandom_range(0, 99) < 3, $urandom_range(0, 199) == 0);
        end
    endtask

    initial begin : stimulus
        logic [ALPHA_W-1:0] phase_size[8];
        int                 phase_len[8];
        int                 idle_wait;

        // single reset at the start of the run
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset alphabet size
        push_item(1, 1'b0, 1'b0);       // front of a fresh list
        push_item(1, 1'b0, 1'b0);       // already at front
        push_item(1024, 1'b0, 1'b0);    // largest symbol from the very back
        push_item(1024, 1'b0, 1'b0);
        push_item(512, 1'b0, 1'b0);
        push_item(0, 1'b0, 1'b0);       // zero symbol is bad
        push_item(1025, 1'b0, 1'b0);    // just above the alphabet
        push_item(2047, 1'b0, 1'b0);    // all ones
        push_item(1536, 1'b0, 1'b0);
        push_item(2, 1'b1, 1'b0);       // restart then look up
        push_item(7, 1'b0, 1'b0);
        push_item(0, 1'b1, 1'b0);       // restart still done on a bad symbol
        push_item(1024, 1'b0, 1'b0);    // back at the end after that restart
        push_item(1023, 1'b0, 1'b0);
        push_item(1, 1'b0, 1'b1);       // sender holds off until all results are in
        push_item(683, 1'b0, 1'b0);
        push_item(341, 1'b0, 1'b0);
        push_item(683, 1'b0, 1'b0);
        push_item(1, 1'b0, 1'b0);

        // alphabet sizes per phase; the list carries over without a restart
        phase_size[0] = 11'd2047;  phase_len[0] = 260;  // saturates to the full list
        phase_size[1] = 11'd1;     phase_len[1] = 80;   // only symbol 1 is valid
        phase_size[2] = 11'd0;     phase_len[2] = 60;   // every symbol is bad
        phase_size[3] = 11'd2;     phase_len[3] = 200;
        phase_size[4] = 11'd1024;  phase_len[4] = 300;  // run without idling
        phase_size[5] = ALPHA_W'($urandom_range(3, 1023));    phase_len[5] = 300;
        phase_size[6] = ALPHA_W'($urandom_range(1025, 2046)); phase_len[6] = 200;
        phase_size[7] = 11'd1024;  phase_len[7] = 200;

        for (int i = 0; i < 8; i++) begin
            wait_idle();
            cfg_write(phase_size[i]);
            @(posedge aclk);
            calm = (i == 4);
            gen_random(phase_len[i], phase_size[i]);
        end

        // let everything drain, bounded
        idle_wait = 0;
        while ((symbol_q.size() != 0 || n_accepted != n_presented || position_q.size() != 0)
               && idle_wait < 500000) begin
            @(negedge aclk);
            idle_wait++;
        end
        repeat (MAX_SYMBOLS + 100) @(posedge aclk);

        if (error_count == 0 && position_q.size() == 0 && symbol_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin : watchdog
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mtf_enc_pkg.sv
hw/rtl/mtf_enc_cell.sv
hw/rtl/mtf_enc_head.sv
hw/rtl/move_to_front_encoder_top.sv
tb/sv/tb.sv
